// File: design/alu32_pkg.sv
// shared types, opcodes and divider step for the 32-bit integer alu
`default_nettype none
package alu32_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned DivSteps = DataWidth;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_SUB  = 5'd1;
   localparam logic [4:0] OP_MULS = 5'd2;
   localparam logic [4:0] OP_MULU = 5'd3;
   localparam logic [4:0] OP_DIVS = 5'd4;
   localparam logic [4:0] OP_DIVU = 5'd5;
   localparam logic [4:0] OP_MODS = 5'd6;
   localparam logic [4:0] OP_MODU = 5'd7;
   localparam logic [4:0] OP_EQ   = 5'd8;
   localparam logic [4:0] OP_NE   = 5'd9;
   localparam logic [4:0] OP_LTS  = 5'd10;
   localparam logic [4:0] OP_LTU  = 5'd11;
   localparam logic [4:0] OP_LES  = 5'd12;
   localparam logic [4:0] OP_LEU  = 5'd13;
   localparam logic [4:0] OP_GTS  = 5'd14;
   localparam logic [4:0] OP_GTU  = 5'd15;
   localparam logic [4:0] OP_GES  = 5'd16;
   localparam logic [4:0] OP_GEU  = 5'd17;
   localparam logic [4:0] OP_LAND = 5'd18;
   localparam logic [4:0] OP_LOR  = 5'd19;
   localparam logic [4:0] OP_AND  = 5'd20;
   localparam logic [4:0] OP_OR   = 5'd21;
   localparam logic [4:0] OP_XOR  = 5'd22;
   localparam logic [4:0] OP_SHL  = 5'd23;
   localparam logic [4:0] OP_SAR  = 5'd24;
   localparam logic [4:0] OP_SHR  = 5'd25;
   localparam logic [4:0] OP_NEG  = 5'd26;
   localparam logic [4:0] OP_LNOT = 5'd27;
   localparam logic [4:0] OP_NOT  = 5'd28;
   localparam logic [4:0] OP_SEXT = 5'd29;
   localparam logic [4:0] OP_ZEXT = 5'd30;
   localparam logic [4:0] OP_TRNC = 5'd31;

   localparam logic [DataWidth-1:0] ByteMask = 32'h0000_00ff;

   typedef struct packed {
      logic [4:0]           op;
      logic [DataWidth-1:0] lhs;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] dq;
      logic [DataWidth-1:0] dvs;
      logic                 neg_q;
      logic                 neg_r;
      logic [DataWidth-1:0] alt;
   } stage_type;

   function automatic stage_type div_step(input stage_type s);
      stage_type        n;
      logic [DataWidth:0] part;
      logic [DataWidth:0] diff;
      n    = s;
      part = {s.rem, s.dq[DataWidth-1]};
      diff = part - {1'b0, s.dvs};
      if (!diff[DataWidth]) begin
         n.rem = diff[DataWidth-1:0];
         n.dq  = {s.dq[DataWidth-2:0], 1'b1};
      end else begin
         n.rem = part[DataWidth-1:0];
         n.dq  = {s.dq[DataWidth-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// File: design/integer_alu_32_top.sv
// top level of the pipelined 32-bit integer alu
// Takes one request per cycle and returns one result per request, in order,
// through an input register, an operand stage holding the 32x32 multiplier
// and all non-divide operations, 32 restoring divider stages (one quotient
// bit each, every operation travels through them), and an output register
// with sign correction. A stall on the result side holds the whole pipeline;
// req_ready is low only while a result waits unaccepted.
// Division by zero gives all ones (or lhs for modulo) with div_by_zero set.
`default_nettype none
module integer_alu_32_top import alu32_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [4:0]           req_op,
   input  wire logic [DataWidth-1:0] req_lhs,
   input  wire logic [DataWidth-1:0] req_rhs,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [DataWidth-1:0] rsp_result,
   output      logic                 rsp_div_by_zero
);

   logic                 advance;
   logic                 in_valid_ff;
   logic [4:0]           in_op_ff;
   logic [DataWidth-1:0] in_lhs_ff;
   logic [DataWidth-1:0] in_rhs_ff;
   logic                 vld_ff [0:DivSteps];
   stage_type            st_ff  [0:DivSteps];
   stage_type            st_in;
   logic                 out_valid_ff;
   logic [DataWidth-1:0] out_result_ff;
   logic [DataWidth-1:0] out_result_in;
   logic                 out_dz_ff;
   logic                 out_dz_in;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_op_ff  <= req_op;
         in_lhs_ff <= req_lhs;
         in_rhs_ff <= req_rhs;
      end
   end

   // operand stage
   always_comb begin
      logic [DataWidth-1:0]   a;
      logic [DataWidth-1:0]   b;
      logic [DataWidth-1:0]   abs_a;
      logic [DataWidth-1:0]   abs_b;
      logic [DataWidth-1:0]   prod;
      logic                   lts;
      logic                   ltu;
      logic                   gts;
      logic                   gtu;
      logic [4:0]             sh;
      a     = in_lhs_ff;
      b     = in_rhs_ff;
      sh    = b[4:0];
      abs_a = a[DataWidth-1] ? (~a + 1'b1) : a;
      abs_b = b[DataWidth-1] ? (~b + 1'b1) : b;
      prod  = a * b;
      lts   = $signed(a) < $signed(b);
      gts   = $signed(b) < $signed(a);
      ltu   = a < b;
      gtu   = b < a;
      st_in       = '0;
      st_in.op    = in_op_ff;
      st_in.lhs   = a;
      case (in_op_ff)
         OP_ADD:  st_in.alt = a + b;
         OP_SUB:  st_in.alt = a - b;
         OP_MULS, OP_MULU: st_in.alt = prod;
         OP_EQ:   st_in.alt = {31'd0, a == b};
         OP_NE:   st_in.alt = {31'd0, a != b};
         OP_LTS:  st_in.alt = {31'd0, lts};
         OP_LTU:  st_in.alt = {31'd0, ltu};
         OP_LES:  st_in.alt = {31'd0, !gts};
         OP_LEU:  st_in.alt = {31'd0, !gtu};
         OP_GTS:  st_in.alt = {31'd0, gts};
         OP_GTU:  st_in.alt = {31'd0, gtu};
         OP_GES:  st_in.alt = {31'd0, !lts};
         OP_GEU:  st_in.alt = {31'd0, !ltu};
         OP_LAND: st_in.alt = {31'd0, (a != '0) && (b != '0)};
         OP_LOR:  st_in.alt = {31'd0, (a != '0) || (b != '0)};
         OP_AND:  st_in.alt = a & b;
         OP_OR:   st_in.alt = a | b;
         OP_XOR:  st_in.alt = a ^ b;
         OP_SHL:  st_in.alt = a << sh;
         OP_SAR:  st_in.alt = DataWidth'($signed(a) >>> sh);
         OP_SHR:  st_in.alt = a >> sh;
         OP_NEG:  st_in.alt = ~a + 1'b1;
         OP_LNOT: st_in.alt = {31'd0, a == '0};
         OP_NOT:  st_in.alt = ~a;
         OP_SEXT: st_in.alt = {{24{a[7]}}, a[7:0]};
         default: st_in.alt = a & ByteMask;
      endcase
      if (in_op_ff == OP_DIVS || in_op_ff == OP_MODS) begin
         st_in.dq  = abs_a;
         st_in.dvs = abs_b;
      end else begin
         st_in.dq  = a;
         st_in.dvs = b;
      end
      st_in.neg_q = (in_op_ff == OP_DIVS) && (a[DataWidth-1] ^ b[DataWidth-1]);
      st_in.neg_r = (in_op_ff == OP_MODS) && a[DataWidth-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DivSteps; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= in_valid_ff;
         for (int i = 0; i < DivSteps; i++) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
      if (advance) begin
         st_ff[0] <= st_in;
         for (int i = 0; i < DivSteps; i++) begin
            st_ff[i+1] <= div_step(st_ff[i]);
         end
      end
   end

   // sign correction and result select
   always_comb begin
      stage_type s;
      logic      is_div;
      s         = st_ff[DivSteps];
      is_div    = s.op inside {[OP_DIVS:OP_MODU]};
      out_dz_in = is_div && (s.dvs == '0);
      if (!is_div) begin
         out_result_in = s.alt;
      end else if (out_dz_in) begin
         out_result_in = (s.op == OP_DIVS || s.op == OP_DIVU) ? '1 : s.lhs;
      end else if (s.op == OP_DIVS || s.op == OP_DIVU) begin
         out_result_in = s.neg_q ? (~s.dq + 1'b1) : s.dq;
      end else begin
         out_result_in = s.neg_r ? (~s.rem + 1'b1) : s.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vld_ff[DivSteps];
      end
      if (advance) begin
         out_result_ff <= out_result_in;
         out_dz_ff     <= out_dz_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result      = out_result_ff;
   assign rsp_div_by_zero = out_dz_ff;

endmodule
`default_nettype wire

// File: design/alu32_checker.sv
// port-level checker for the integer alu and its bind
`default_nettype none
module alu32_checker import alu32_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [DataWidth-1:0] rsp_result,
   input wire logic                 rsp_div_by_zero
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
         && $stable(rsp_div_by_zero))
      else $error("result changed while stalled");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("ready low with free output");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !reset |=> !rsp_valid)
      else $error("result without request");

endmodule

bind integer_alu_32_top alu32_checker u_alu32_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result      (rsp_result),
   .rsp_div_by_zero (rsp_div_by_zero)
);
`default_nettype wire
